// ===== src/cpf_pkg.sv =====
package cpf_pkg;

   // Input action codes
   localparam logic ACTION_START   = 1'b0;
   localparam logic ACTION_PAYLOAD = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [1:0] STATUS_DROPPED  = 2'd2;

   // Command kinds passed from front to back
   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;
   localparam logic [1:0] KIND_DROP    = 2'd3;

   // Register indexes
   localparam logic [2:0] REG_CRC_SEED    = 3'd0;
   localparam logic [2:0] REG_CRC_POLY    = 3'd1;
   localparam logic [2:0] REG_SYNC_FIRST  = 3'd2;
   localparam logic [2:0] REG_SYNC_SECOND = 3'd3;
   localparam logic [2:0] REG_VERSION     = 3'd4;
   localparam logic [2:0] REG_MAX_FRAME   = 3'd5;

   // Register reset values
   localparam logic [15:0] RST_CRC_SEED    = 16'hFFFF;
   localparam logic [15:0] RST_CRC_POLY    = 16'h1021;
   localparam logic [7:0]  RST_SYNC_FIRST  = 8'hAA;
   localparam logic [7:0]  RST_SYNC_SECOND = 8'h55;
   localparam logic [7:0]  RST_VERSION     = 8'h01;
   localparam logic [16:0] RST_MAX_FRAME   = 17'd65549;

   // Header + CRC byte count
   localparam logic [16:0] FRAME_OVERHEAD = 17'd14;

   // Default depth of the command queue
   localparam int CPF_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [15:0] crc_seed;
      logic [15:0] crc_poly;
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [7:0]  version;
      logic [16:0] max_frame;
   } cfg_type;

   // data_byte holds the packet type on a start, the byte on a payload
   typedef struct packed {
      logic [1:0]  kind;
      logic        last;
      logic [7:0]  data_byte;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [15:0] len;
   } cmd_type;

   // One byte through the MSB-first CRC-16
   function automatic logic [15:0] crc_feed(input logic [15:0] crc_cur,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc_cur ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== src/cpf_csr.sv =====
module cpf_csr
   import cpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CRC_SEED:    cfg_in.crc_seed    = csr_data[15:0];
            REG_CRC_POLY:    cfg_in.crc_poly    = csr_data[15:0];
            REG_SYNC_FIRST:  cfg_in.sync_first  = csr_data[7:0];
            REG_SYNC_SECOND: cfg_in.sync_second = csr_data[7:0];
            REG_VERSION:     cfg_in.version     = csr_data[7:0];
            REG_MAX_FRAME:   cfg_in.max_frame   = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_seed    <= RST_CRC_SEED;
         cfg_ff.crc_poly    <= RST_CRC_POLY;
         cfg_ff.sync_first  <= RST_SYNC_FIRST;
         cfg_ff.sync_second <= RST_SYNC_SECOND;
         cfg_ff.version     <= RST_VERSION;
         cfg_ff.max_frame   <= RST_MAX_FRAME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/cpf_front.sv =====
module cpf_front
   import cpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_accept,
   input  logic        req_action,
   input  logic [7:0]  req_packet_type,
   input  logic [15:0] req_sequence_number,
   input  logic [31:0] req_timestamp_ms,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_payload_byte,
   input  logic [16:0] max_frame,
   output cmd_type     cmd
);

   // Bytes still expected in the open frame; zero means no frame open
   logic [15:0] remain_ff;
   logic [15:0] remain_in;
   logic [16:0] total;

   assign total = {1'b0, req_payload_length} + FRAME_OVERHEAD;

   // Classify the item and track the frame
   always_comb begin
      cmd.seq       = req_sequence_number;
      cmd.ts        = req_timestamp_ms;
      cmd.len       = req_payload_length;
      cmd.last      = 1'b0;
      cmd.data_byte = req_packet_type;
      remain_in     = remain_ff;
      if (req_action == ACTION_START) begin
         if (total > max_frame) begin
            cmd.kind  = KIND_REJECT;
            remain_in = 16'd0;
         end else begin
            cmd.kind  = KIND_START;
            remain_in = req_payload_length;
         end
      end else begin
         cmd.data_byte = req_payload_byte;
         if (remain_ff == 16'd0) begin
            cmd.kind = KIND_DROP;
         end else begin
            cmd.kind  = KIND_PAYLOAD;
            cmd.last  = (remain_ff == 16'd1);
            remain_in = remain_ff - 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 16'd0;
      end else if (req_accept) begin
         remain_ff <= remain_in;
      end
   end

endmodule

// ===== src/cpf_queue.sv =====
module cpf_queue
   import cpf_pkg::*;
#(
   parameter int DEPTH = CPF_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[head_ff];

   // Pointer and fill tracking
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/cpf_back.sv =====
module cpf_back
   import cpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cmd_empty,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic [1:0]  rsp_status
);

   // Byte position within the current command
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] crc_ff, crc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic        last_ff, last_in;
   logic [1:0]  status_ff, status_in;

   logic        emit;
   logic        done;

   assign emit      = !cmd_empty && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop   = emit && done;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = end_ff;
   assign rsp_run_last  = last_ff;
   assign rsp_status    = status_ff;

   // Byte selection and CRC update for the head command
   always_comb begin
      byte_in   = 8'h00;
      end_in    = 1'b0;
      last_in   = 1'b0;
      status_in = STATUS_OK;
      done      = 1'b0;
      crc_in    = crc_ff;
      unique case (cmd.kind)
         KIND_START: begin
            unique case (phase_ff)
               4'd0:  byte_in = cfg.sync_first;
               4'd1:  byte_in = cfg.sync_second;
               4'd2:  byte_in = cfg.version;
               4'd3:  byte_in = cmd.data_byte;
               4'd4:  byte_in = cmd.seq[7:0];
               4'd5:  byte_in = cmd.seq[15:8];
               4'd6:  byte_in = cmd.ts[7:0];
               4'd7:  byte_in = cmd.ts[15:8];
               4'd8:  byte_in = cmd.ts[23:16];
               4'd9:  byte_in = cmd.ts[31:24];
               4'd10: byte_in = cmd.len[7:0];
               4'd11: byte_in = cmd.len[15:8];
               4'd12: byte_in = crc_ff[7:0];
               4'd13: byte_in = crc_ff[15:8];
               default: byte_in = 8'h00;
            endcase
            if (phase_ff == 4'd0) begin
               crc_in = cfg.crc_seed;
            end else if (phase_ff >= 4'd2 && phase_ff <= 4'd11) begin
               crc_in = crc_feed(crc_ff, byte_in, cfg.crc_poly);
            end
            // zero-length frame carries its CRC straight after the header
            if (phase_ff == 4'd11 && cmd.len != 16'd0) begin
               last_in = 1'b1;
               done    = 1'b1;
            end
            if (phase_ff == 4'd13) begin
               end_in  = 1'b1;
               last_in = 1'b1;
               done    = 1'b1;
            end
         end
         KIND_PAYLOAD: begin
            unique case (phase_ff)
               4'd0: begin
                  byte_in = cmd.data_byte;
                  crc_in  = crc_feed(crc_ff, cmd.data_byte, cfg.crc_poly);
                  last_in = !cmd.last;
                  done    = !cmd.last;
               end
               4'd1: byte_in = crc_ff[7:0];
               default: begin
                  byte_in = crc_ff[15:8];
                  end_in  = 1'b1;
                  last_in = 1'b1;
                  done    = 1'b1;
               end
            endcase
         end
         KIND_REJECT: begin
            status_in = STATUS_TOO_LONG;
            last_in   = 1'b1;
            done      = 1'b1;
         end
         KIND_DROP: begin
            status_in = STATUS_DROPPED;
            last_in   = 1'b1;
            done      = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   // Phase step and output register control
   always_comb begin
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         phase_in     = done ? 4'd0 : phase_ff + 4'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= 16'd0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            crc_ff <= crc_in;
         end
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff   <= byte_in;
         end_ff    <= end_in;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

endmodule

// ===== src/crc16_packet_framer_top.sv =====
// An item goes into the command queue; its first result byte is then registered at the output.
// Throughput: one result byte per cycle while rsp_ready is high, set by the back-end serializer
// and its CRC step. A start item gives its header bytes (and the CRC bytes with zero length), a
// payload byte its own byte (and the CRC bytes for the last one), a rejected or dropped item a
// status result; the 4-deep command queue lets the input take one item per cycle until it fills.
// Reset: clears frame tracking, the queue and the output valid flag; config returns to defaults.
module crc16_packet_framer_top
   import cpf_pkg::*;
#(
   parameter int QUEUE_DEPTH = CPF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_packet_type,
   input  logic [15:0] req_sequence_number,
   input  logic [31:0] req_timestamp_ms,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   cfg_type cfg;
   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   logic    req_accept;

   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   // Configuration registers
   cpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Front: classify items, track the open frame
   cpf_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_accept          (req_accept),
      .req_action          (req_action),
      .req_packet_type     (req_packet_type),
      .req_sequence_number (req_sequence_number),
      .req_timestamp_ms    (req_timestamp_ms),
      .req_payload_length  (req_payload_length),
      .req_payload_byte    (req_payload_byte),
      .max_frame           (cfg.max_frame),
      .cmd                 (front_cmd)
   );

   // Command queue between front and back
   cpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (head_cmd)
   );

   // Back: byte serializer with running CRC
   cpf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd_empty     (q_empty),
      .cmd           (head_cmd),
      .cmd_pop       (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_run_last  (rsp_run_last),
      .rsp_status    (rsp_status)
   );

endmodule

// ===== tb/tb_crc16_packet_framer_top.sv =====
module tb_crc16_packet_framer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cpf_pkg::*;

   // Register slots past the last real one; writes there must be ignored
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   localparam int HDR_BYTES      = 12;
   localparam int RSP_HOLD_CYCLES = 300;

   typedef struct packed {
      logic        action;
      logic [7:0]  ptype;
      logic [15:0] seq;
      logic [31:0] stamp;
      logic [15:0] len;
      logic [7:0]  pbyte;
   } framer_req_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fend;
      logic       last;
      logic [1:0] status;
   } framer_byte_type;

   // Tracks framer state and the bytes it owes, in transfer order
   class framed_byte_checker;
      logic [15:0] seed;
      logic [15:0] poly;
      logic [7:0]  sync_a;
      logic [7:0]  sync_b;
      logic [7:0]  version;
      logic [16:0] max_frame;
      logic [15:0] crc_acc;
      logic [15:0] left;
      bit          open;
      framer_byte_type expected_bytes[$];
      int          errors;

      function void reset_model();
         seed      = RST_CRC_SEED;
         poly      = RST_CRC_POLY;
         sync_a    = RST_SYNC_FIRST;
         sync_b    = RST_SYNC_SECOND;
         version   = RST_VERSION;
         max_frame = RST_MAX_FRAME;
         crc_acc   = '0;
         left      = '0;
         open      = 0;
         errors    = 0;
         expected_bytes.delete();
      endfunction

      function void write_reg(logic [2:0] idx, logic [16:0] value);
         case (idx)
            REG_CRC_SEED:    seed = value[15:0];
            REG_CRC_POLY:    poly = value[15:0];
            REG_SYNC_FIRST:  sync_a = value[7:0];
            REG_SYNC_SECOND: sync_b = value[7:0];
            REG_VERSION:     version = value[7:0];
            REG_MAX_FRAME:   max_frame = value;
            default: ;
         endcase
      endfunction

      // Bitwise form: each data bit, MSB first, meets the register's top bit
      function logic [15:0] crc_next(logic [15:0] acc, logic [7:0] b);
         logic [15:0] r;
         r = acc;
         for (int i = 7; i >= 0; i--) begin
            if (r[15] ^ b[i]) begin
               r = {r[14:0], 1'b0} ^ poly;
            end else begin
               r = {r[14:0], 1'b0};
            end
         end
         return r;
      endfunction

      function void owe(logic [7:0] data, logic fend, logic last, logic [1:0] status);
         framer_byte_type b;
         b.data   = data;
         b.fend   = fend;
         b.last   = last;
         b.status = status;
         expected_bytes.push_back(b);
      endfunction

      function void close_with_crc();
         owe(crc_acc[7:0], 1'b0, 1'b0, STATUS_OK);
         owe(crc_acc[15:8], 1'b1, 1'b1, STATUS_OK);
         open = 0;
         left = '0;
      endfunction

      function void note_item(framer_req_type it);
         logic [7:0] hdr [HDR_BYTES];
         if (it.action == ACTION_START) begin
            // size check is done at 17 bits, no wrap
            if (({1'b0, it.len} + FRAME_OVERHEAD) > max_frame) begin
               open = 0;
               left = '0;
               owe(8'h00, 1'b0, 1'b1, STATUS_TOO_LONG);
               return;
            end
            hdr[0]  = sync_a;
            hdr[1]  = sync_b;
            hdr[2]  = version;
            hdr[3]  = it.ptype;
            hdr[4]  = it.seq[7:0];
            hdr[5]  = it.seq[15:8];
            hdr[6]  = it.stamp[7:0];
            hdr[7]  = it.stamp[15:8];
            hdr[8]  = it.stamp[23:16];
            hdr[9]  = it.stamp[31:24];
            hdr[10] = it.len[7:0];
            hdr[11] = it.len[15:8];
            // CRC covers version onward, sync bytes excluded
            crc_acc = seed;
            for (int i = 2; i < HDR_BYTES; i++) crc_acc = crc_next(crc_acc, hdr[i]);
            for (int i = 0; i < HDR_BYTES; i++) begin
               owe(hdr[i], 1'b0, (i == HDR_BYTES - 1) && (it.len != 0), STATUS_OK);
            end
            if (it.len == 0) begin
               close_with_crc();
            end else begin
               open = 1;
               left = it.len;
            end
            return;
         end
         // stray payload byte
         if (!open || left == 0) begin
            owe(8'h00, 1'b0, 1'b1, STATUS_DROPPED);
            return;
         end
         crc_acc = crc_next(crc_acc, it.pbyte);
         left = left - 16'd1;
         if (left != 0) begin
            owe(it.pbyte, 1'b0, 1'b1, STATUS_OK);
         end else begin
            owe(it.pbyte, 1'b0, 1'b0, STATUS_OK);
            close_with_crc();
         end
      endfunction

      function void check_byte(framer_byte_type got);
         framer_byte_type want;
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte %02h status %0d", got.data, got.status);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.data !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, got.data);
            errors++;
         end
         if (got.fend !== want.fend) begin
            $error("frame_end: expected %0b, got %0b", want.fend, got.fend);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [7:0]  req_packet_type;
   logic [15:0] req_sequence_number;
   logic [31:0] req_timestamp_ms;
   logic [15:0] req_payload_length;
   logic [7:0]  req_payload_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;
   logic        rsp_run_last;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [16:0] csr_data;

   framed_byte_checker sb;
   bit calm;       // no idling on either side while set
   bit stall_kick; // asks the receiver for a long hold-off

   crc16_packet_framer_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_packet_type     (req_packet_type),
      .req_sequence_number (req_sequence_number),
      .req_timestamp_ms    (req_timestamp_ms),
      .req_payload_length  (req_payload_length),
      .req_payload_byte    (req_payload_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_run_last        (rsp_run_last),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Observe every transfer on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) begin
            sb.note_item('{action: req_action, ptype: req_packet_type,
                           seq: req_sequence_number, stamp: req_timestamp_ms,
                           len: req_payload_length, pbyte: req_payload_byte});
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_byte('{data: rsp_out_byte, fend: rsp_frame_end,
                            last: rsp_run_last, status: rsp_status});
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (stall_kick) begin
            stall_kick = 0;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 36);
         end
      end
   end

   function automatic framer_req_type start_item(logic [7:0] ptype, logic [15:0] seq,
                                                 logic [31:0] stamp, logic [15:0] len);
      framer_req_type it;
      it.action = ACTION_START;
      it.ptype  = ptype;
      it.seq    = seq;
      it.stamp  = stamp;
      it.len    = len;
      it.pbyte  = 8'($urandom_range(0, 255));
      return it;
   endfunction

   function automatic framer_req_type payload_item(logic [7:0] b);
      framer_req_type it;
      it.action = ACTION_PAYLOAD;
      it.ptype  = 8'($urandom_range(0, 255));
      it.seq    = 16'($urandom_range(0, 65535));
      it.stamp  = $urandom;
      it.len    = 16'($urandom_range(0, 65535));
      it.pbyte  = b;
      return it;
   endfunction

   // Offer one item after a random gap; returns at the edge of its transfer
   task automatic send_item(input framer_req_type it);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_action          <= it.action;
      req_packet_type     <= it.ptype;
      req_sequence_number <= it.seq;
      req_timestamp_ms    <= it.stamp;
      req_payload_length  <= it.len;
      req_payload_byte    <= it.pbyte;
      do @(posedge clock); while (!req_ready);
   endtask

   // Start with random header fields (skipped when len < 0), then nb payload bytes
   task automatic send_frame(input int len, input int nb);
      if (len >= 0) begin
         send_item(start_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                              $urandom, 16'(len)));
      end
      repeat (nb) send_item(payload_item(8'($urandom_range(0, 255))));
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Header and CRC registers; unused upper data bits get random junk
   task automatic load_framing(input logic [15:0] seed, input logic [15:0] poly,
                               input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] ver);
      write_reg(REG_CRC_SEED, {1'($urandom_range(0, 1)), seed});
      write_reg(REG_CRC_POLY, {1'($urandom_range(0, 1)), poly});
      write_reg(REG_SYNC_FIRST, {9'($urandom_range(0, 511)), s1});
      write_reg(REG_SYNC_SECOND, {9'($urandom_range(0, 511)), s2});
      write_reg(REG_VERSION, {9'($urandom_range(0, 511)), ver});
   endtask

   // Stop offering and wait until every owed byte has come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (8) @(posedge clock);
   endtask

   // Mostly complete frames with random content; some noise
   task automatic random_phase(input int n_items);
      int sent;
      int pick;
      int len;
      int nb;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            nb  = len;
         end else if (pick < 80) begin
            // full-range length, cut short by the next start
            len = $urandom_range(0, 65535);
            nb  = $urandom_range(0, 3);
         end else if (pick < 90) begin
            len = $urandom_range(2, 8);
            nb  = $urandom_range(0, len - 1);
         end else begin
            len = -1;
            nb  = $urandom_range(1, 2);
         end
         send_frame(len, nb);
         sent += nb + ((len >= 0) ? 1 : 0);
      end
   endtask

   initial begin
      sb = new;
      sb.reset_model();
      calm                = 0;
      stall_kick          = 0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_action          = ACTION_START;
      req_packet_type     = '0;
      req_sequence_number = '0;
      req_timestamp_ms    = '0;
      req_payload_length  = '0;
      req_payload_byte    = '0;
      rsp_ready           = 1'b0;
      csr_valid           = 1'b0;
      csr_index           = REG_CRC_SEED;
      csr_data            = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset config: stray byte, empty frame, field extremes,
      // largest legal length, restart over an open frame, byte after close
      send_item(payload_item(8'hFF));
      send_item(start_item(8'h00, 16'h0000, 32'h0000_0000, 16'd0));
      send_item(start_item(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd3));
      send_item(payload_item(8'h00));
      send_item(payload_item(8'hFF));
      send_item(payload_item(8'hA5));
      send_item(start_item(8'h5A, 16'h1234, 32'h89AB_CDEF, 16'hFFFF));
      send_item(payload_item(8'h3C));
      send_frame(2, 2);
      send_item(payload_item(8'h77));
      wait_idle();

      // Directed, tight size limit and unusual framing bytes
      load_framing(16'h0000, 16'h8005, 8'h00, 8'hFF, 8'hFF);
      write_reg(REG_MAX_FRAME, 17'd20);
      write_reg(REG_SPARE_LO, 17'h1FFFF);
      write_reg(REG_SPARE_HI, 17'h00000);
      send_frame(6, 6);    // exactly at the limit
      send_frame(7, 0);    // one over: rejected
      send_frame(2, 1);
      send_frame(7, 0);    // rejected while a frame is open
      send_frame(-1, 1);   // nothing open any more
      send_frame(0, 0);
      wait_idle();

      // Random framing, no size limit in practice
      load_framing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      write_reg(REG_MAX_FRAME, 17'h1FFFF);
      random_phase(70);
      wait_idle();

      // Long receiver hold-off while the sender keeps pushing
      stall_kick = 1;
      send_frame(30, 30);
      random_phase(40);
      wait_idle();

      // All-ones CRC, small random limit, no idling at all
      calm = 1;
      load_framing(16'hFFFF, 16'hFFFF, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      write_reg(REG_MAX_FRAME, 17'($urandom_range(14, 40)));
      random_phase(70);
      wait_idle();
      calm = 0;

      // Zero limit: every start rejected
      write_reg(REG_MAX_FRAME, 17'd0);
      random_phase(30);
      wait_idle();

      // Zero seed and polynomial, default limit
      load_framing(16'h0000, 16'h0000, RST_SYNC_FIRST, RST_SYNC_SECOND, RST_VERSION);
      write_reg(REG_MAX_FRAME, RST_MAX_FRAME);
      random_phase(70);
      wait_idle();

      // Everything random
      load_framing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      write_reg(REG_MAX_FRAME, 17'($urandom_range(14, 131071)));
      random_phase(100);
      wait_idle();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/cpf_pkg.sv
src/cpf_csr.sv
src/cpf_front.sv
src/cpf_queue.sv
src/cpf_back.sv
src/crc16_packet_framer_top.sv
tb/tb_crc16_packet_framer_top.sv
